// ===== hdl/fbt_pkg.sv =====
// ----------------------------------------------------------------------------
// fbt_pkg: shared types and constants of the flow bypass table
// Commands, register indexes, table geometry and controller/datapath structs.
// ----------------------------------------------------------------------------
package fbt_pkg;

  localparam int unsigned FlowEntries = 256;
  localparam int unsigned IdxW        = (FlowEntries > 1) ? $clog2(FlowEntries) : 1;
  localparam int unsigned CntW        = $clog2(FlowEntries + 1);
  localparam int unsigned KeyW        = 96;
  localparam int unsigned TimeW       = 48;
  localparam int unsigned CleanW      = 32;
  localparam int unsigned OutCntW     = 9;

  localparam logic [2:0] CmdTrack  = 3'd0;
  localparam logic [2:0] CmdQuery  = 3'd1;
  localparam logic [2:0] CmdMark   = 3'd2;
  localparam logic [2:0] CmdRevoke = 3'd3;
  localparam logic [2:0] CmdSweep  = 3'd4;

  localparam logic [1:0] RegEnable    = 2'd0;
  localparam logic [1:0] RegThreshold = 2'd1;
  localparam logic [1:0] RegTimeout   = 2'd2;

  // Commands from controller to datapath.
  typedef struct packed {
    logic           latch;     // capture the input item
    logic           rd;        // read the entry at scan_idx
    logic           scan_clr;  // restart the scan counter
    logic           scan_inc;  // advance the scan counter
    logic           eval;      // examine the entry read last cycle
    logic           commit;    // apply the command to the chosen entry
    logic           finish;    // drive the result strobe
  } fbt_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic           scan_last; // scan counter is at the last entry
    logic           is_sweep;
    logic           is_known;  // command 0..3
  } fbt_stat_t;

endpackage

// ===== hdl/fbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbt_ctrl: sequencer of the flow bypass table
// Walks the table once per keyed (lookup) or sweep (purge) item, else skips.
// ----------------------------------------------------------------------------
module fbt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  fbt_pkg::fbt_stat_t stat_i,
  output fbt_pkg::fbt_cmd_t  cmd_o,
  output logic               busy_o
);
  import fbt_pkg::*;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StScan   = 5'b00010,
    StDrain  = 5'b00100,
    StCommit = 5'b01000,
    StDone   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.latch    = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = StScan;
        end
      end
      StScan: begin
        // Unknown commands skip the walk.
        if (!stat_i.is_known && !stat_i.is_sweep) begin
          state_d = StDone;
        end else begin
          cmd_o.rd       = 1'b1;
          cmd_o.scan_inc = 1'b1;
          cmd_o.eval     = last_q;
          last_d         = 1'b1;
          if (stat_i.scan_last) state_d = StDrain;
        end
      end
      StDrain: begin
        cmd_o.eval = 1'b1;
        last_d     = 1'b0;
        state_d    = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StDone;
      end
      StDone: begin
        cmd_o.finish = 1'b1;
        last_d       = 1'b0;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

endmodule

// ===== hdl/fbt_datapath.sv =====
// ----------------------------------------------------------------------------
// fbt_datapath: entry memory, scan logic and totals of the flow bypass table
// Holds the entry store, the valid and flag bits and the running counts.
// ----------------------------------------------------------------------------
module fbt_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fbt_pkg::fbt_cmd_t                   cmd_i,
  output fbt_pkg::fbt_stat_t                  stat_o,
  input  logic [2:0]                          command_i,
  input  logic [31:0]                         src_ip_i,
  input  logic [31:0]                         dst_ip_i,
  input  logic [15:0]                         src_port_i,
  input  logic [15:0]                         dst_port_i,
  input  logic [fbt_pkg::TimeW-1:0]           now_us_i,
  input  logic                                cfg_enable_i,
  input  logic [fbt_pkg::CleanW-1:0]          cfg_threshold_i,
  input  logic [fbt_pkg::TimeW-1:0]           cfg_timeout_i,
  output logic                                result_valid_o,
  output logic                                bypass_o,
  output logic                                found_o,
  output logic                                table_full_o,
  output logic [fbt_pkg::OutCntW-1:0]         tracked_count_o,
  output logic [fbt_pkg::OutCntW-1:0]         bypassed_count_o
);
  import fbt_pkg::*;

  localparam int unsigned EntW = KeyW + TimeW + CleanW;

  // Key, last-seen and clean count in one memory; valid and flag in flops.
  logic [EntW-1:0]        mem_q [FlowEntries];
  logic [FlowEntries-1:0] valid_q;
  logic [FlowEntries-1:0] flag_q;

  logic [2:0]        cmd_q;
  logic [KeyW-1:0]   key_q;
  logic [TimeW-1:0]  now_q;
  logic [IdxW-1:0]   scan_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [EntW-1:0]   rd_q;
  logic              hit_q, free_q;
  logic [IdxW-1:0]   hit_idx_q, free_idx_q;
  logic [CleanW-1:0] hit_clean_q;
  logic [CntW-1:0]   occ_q, byp_q;

  logic [KeyW-1:0]   rd_key;
  logic [TimeW-1:0]  rd_seen;
  logic [CleanW-1:0] rd_clean;
  logic [TimeW-1:0]  idle;
  logic              rd_valid, rd_match, rd_stale;

  assign rd_key   = rd_q[EntW-1 -: KeyW];
  assign rd_seen  = rd_q[CleanW +: TimeW];
  assign rd_clean = rd_q[CleanW-1:0];
  assign rd_valid = valid_q[rd_idx_q];
  assign rd_match = rd_valid && (rd_key == key_q);
  assign idle     = now_q - rd_seen;
  assign rd_stale = rd_valid && (now_q > rd_seen) && (idle > cfg_timeout_i);

  assign stat_o.scan_last = (scan_q == IdxW'(FlowEntries - 1));
  assign stat_o.is_sweep  = (cmd_q == CmdSweep);
  assign stat_o.is_known  = (cmd_q <= CmdRevoke);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= command_i;
      key_q <= {src_ip_i, dst_ip_i, src_port_i, dst_port_i};
      now_q <= now_us_i;
    end
    if (cmd_i.rd) begin
      rd_q     <= mem_q[scan_q];
      rd_idx_q <= scan_q;
    end
    if (cmd_i.eval && rd_match && !hit_q) begin
      hit_idx_q   <= rd_idx_q;
      hit_clean_q <= rd_clean;
    end
    if (cmd_i.eval && !rd_valid && !free_q) free_idx_q <= rd_idx_q;
  end

  // Commit of the chosen entry.
  logic              ins_ok, do_ins, do_write, set_flag, clr_flag;
  logic [IdxW-1:0]   tgt;
  logic [CleanW-1:0] base_clean, new_clean;
  logic [TimeW-1:0]  new_seen;
  logic              tgt_flag;
  logic [TimeW-1:0]  rd_seen_hold;

  always_comb begin
    do_ins     = 1'b0;
    do_write   = 1'b0;
    set_flag   = 1'b0;
    clr_flag   = 1'b0;
    new_seen   = now_q;
    tgt        = hit_q ? hit_idx_q : free_idx_q;
    ins_ok     = hit_q || free_q;
    base_clean = hit_q ? hit_clean_q : '0;
    new_clean  = base_clean;
    tgt_flag   = hit_q && flag_q[hit_idx_q];
    case (cmd_q)
      CmdTrack: begin
        if (cfg_enable_i && ins_ok) begin
          do_ins    = !hit_q;
          do_write  = 1'b1;
          new_clean = (base_clean == '1) ? base_clean : base_clean + 1'b1;
          set_flag  = (new_clean >= cfg_threshold_i) && !tgt_flag;
        end
      end
      CmdMark: begin
        if (ins_ok) begin
          do_ins   = !hit_q;
          do_write = !hit_q;
          new_seen = '0;
          set_flag = !tgt_flag;
        end
      end
      CmdRevoke: begin
        if (hit_q) begin
          do_write  = 1'b1;
          new_seen  = rd_seen_hold;
          new_clean = '0;
          clr_flag  = tgt_flag;
        end
      end
      default: ;
    endcase
  end

  // Revoke keeps last-seen: hold it from the hit read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && rd_match && !hit_q) rd_seen_hold <= rd_seen;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && do_write) mem_q[tgt] <= {key_q, new_seen, new_clean};
  end

  logic sweep_kill;
  assign sweep_kill = cmd_i.eval && stat_o.is_sweep && rd_stale;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      flag_q         <= '0;
      occ_q          <= '0;
      byp_q          <= '0;
      scan_q         <= '0;
      hit_q          <= 1'b0;
      free_q         <= 1'b0;
      result_valid_o <= 1'b0;
      bypass_o       <= 1'b0;
      found_o        <= 1'b0;
      table_full_o   <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.finish;
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.eval) begin
        if (rd_match) hit_q <= 1'b1;
        if (!rd_valid) free_q <= 1'b1;
      end
      if (sweep_kill) begin
        valid_q[rd_idx_q] <= 1'b0;
        flag_q[rd_idx_q]  <= 1'b0;
        occ_q             <= occ_q - 1'b1;
        if (flag_q[rd_idx_q]) byp_q <= byp_q - 1'b1;
      end
      if (cmd_i.commit) begin
        if (do_ins) begin
          valid_q[tgt] <= 1'b1;
          flag_q[tgt]  <= set_flag;
          occ_q        <= occ_q + 1'b1;
        end else if (set_flag) begin
          flag_q[tgt] <= 1'b1;
        end else if (clr_flag) begin
          flag_q[tgt] <= 1'b0;
        end
        if (set_flag) byp_q <= byp_q + 1'b1;
        if (clr_flag) byp_q <= byp_q - 1'b1;
      end
      if (cmd_i.finish) begin
        bypass_o     <= (cmd_q == CmdQuery) && cfg_enable_i && hit_q && flag_q[hit_idx_q];
        found_o      <= stat_o.is_known && hit_q;
        table_full_o <= !hit_q && !free_q &&
                        (((cmd_q == CmdTrack) && cfg_enable_i) || (cmd_q == CmdMark));
      end
    end
  end

  assign tracked_count_o  = OutCntW'(occ_q);
  assign bypassed_count_o = OutCntW'(byp_q);

endmodule

// ===== hdl/flow_bypass_table_top.sv =====
// ----------------------------------------------------------------------------
// flow_bypass_table_top: per-flow table with idle timeout and bypass flags
// Top level: configuration registers, sequencer and entry datapath.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. Every keyed
// command (track, query, mark, revoke) and every sweep walks the whole
// entry memory through its single read port, one entry per cycle, then
// commits and reports; an unknown command skips the walk and only reports.
// The one result of each item appears for exactly one cycle with
// result_valid_o high and must be taken then, since the block cannot be
// stalled. Configuration writes are always ready and should be made while
// the block is idle. The entry memory needs no clearing after reset: valid
// bits live in flops.
module flow_bypass_table_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [2:0]                  command_i,
  input  logic [31:0]                 src_ip_i,
  input  logic [31:0]                 dst_ip_i,
  input  logic [15:0]                 src_port_i,
  input  logic [15:0]                 dst_port_i,
  input  logic [47:0]                 now_us_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [47:0]                 cfg_data_i,
  output logic                        result_valid_o,
  output logic                        bypass_o,
  output logic                        found_o,
  output logic                        table_full_o,
  output logic [8:0]                  tracked_count_o,
  output logic [8:0]                  bypassed_count_o
);
  import fbt_pkg::*;

  logic              enable_q;
  logic [CleanW-1:0] threshold_q;
  logic [TimeW-1:0]  timeout_q;

  assign cfg_ready_o = 1'b1;

  // Register file: writes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      threshold_q <= CleanW'(100);
      timeout_q   <= TimeW'(30000000);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegEnable:    enable_q    <= cfg_data_i[0];
        RegThreshold: threshold_q <= cfg_data_i[CleanW-1:0];
        RegTimeout:   timeout_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fbt_cmd_t  cmd;
  fbt_stat_t stat;
  logic      busy;

  fbt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  assign busy_o = busy;

  fbt_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .command_i        (command_i),
    .src_ip_i         (src_ip_i),
    .dst_ip_i         (dst_ip_i),
    .src_port_i       (src_port_i),
    .dst_port_i       (dst_port_i),
    .now_us_i         (now_us_i),
    .cfg_enable_i     (enable_q),
    .cfg_threshold_i  (threshold_q),
    .cfg_timeout_i    (timeout_q),
    .result_valid_o   (result_valid_o),
    .bypass_o         (bypass_o),
    .found_o          (found_o),
    .table_full_o     (table_full_o),
    .tracked_count_o  (tracked_count_o),
    .bypassed_count_o (bypassed_count_o)
  );

endmodule

// ===== hdl/fbt_checker.sv =====
// ----------------------------------------------------------------------------
// fbt_checker: port-level checks of the flow bypass table
// Watches handshake and result ports of the top level.
// ----------------------------------------------------------------------------
module fbt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       result_valid_o,
  input logic       bypass_o,
  input logic       found_o,
  input logic       table_full_o,
  input logic [8:0] tracked_count_o,
  input logic [8:0] bypassed_count_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted item did not raise busy");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than a cycle");

  a_bypass_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && bypass_o) |-> found_o) else $error("bypass without found");

  a_full_notfound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && table_full_o) |-> !found_o) else $error("full with found");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (bypassed_count_o <= tracked_count_o))
    else $error("bypassed exceeds tracked");
endmodule

bind flow_bypass_table_top fbt_checker u_fbt_checker (.*);
